>>> hdl/ata_pio_chs_sector_sequencer_top_assert.svh
// Assertion macros for the ATA PIO CHS sector sequencer
`ifndef ATA_PIO_CHS_SECTOR_SEQUENCER_TOP_ASSERT_SVH
`define ATA_PIO_CHS_SECTOR_SEQUENCER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define APS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define APS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the ATA PIO CHS sector sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package aps_pkg;
    localparam int unsigned WORDS_PER_SECTOR = 256;
    localparam int unsigned WIDX_W = $clog2(WORDS_PER_SECTOR) + 1;
    localparam logic [31:0] BUS_BASE = 32'hb400_2000;
    localparam logic [7:0]  ST_BUSY  = 8'h80;
    localparam logic [7:0]  ST_DRQ   = 8'h08;
    localparam logic [7:0]  DEV_SEL  = 8'ha0;
    localparam logic [7:0]  CMD_READ = 8'h20;
    localparam logic [7:0]  CMD_WRITE = 8'h30;
    localparam logic [7:0]  POLL_RESET = 8'd100;

    // input actions
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_STATUS = 2'd1;
    localparam logic [1:0] ACT_DATA   = 2'd2;

    // result kinds
    localparam logic [2:0] K_BUS_WR  = 3'd0;
    localparam logic [2:0] K_BUS_RD  = 3'd1;
    localparam logic [2:0] K_WORD    = 3'd2;
    localparam logic [2:0] K_DONE    = 3'd3;
    localparam logic [2:0] K_TIMEOUT = 3'd4;

    // task-file register indexes
    localparam logic [2:0] R_DATA  = 3'd0;
    localparam logic [2:0] R_COUNT = 3'd2;
    localparam logic [2:0] R_SECT  = 3'd3;
    localparam logic [2:0] R_CYLL  = 3'd4;
    localparam logic [2:0] R_CYLH  = 3'd5;
    localparam logic [2:0] R_HEAD  = 3'd6;
    localparam logic [2:0] R_CMD   = 3'd7;

    // config register indexes
    localparam logic [1:0] CFG_HEADS = 2'd0;
    localparam logic [1:0] CFG_SPT   = 2'd1;
    localparam logic [1:0] CFG_POLL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic start_div;   // begin CHS conversion
        logic emit;        // push one result
        logic [2:0] kind;
        logic [2:0] reg_idx;
        logic [2:0] src;   // data source select
        logic last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_status;

    // data source codes
    localparam logic [2:0] SRC_ZERO  = 3'd0;
    localparam logic [2:0] SRC_COUNT = 3'd1;
    localparam logic [2:0] SRC_SECT  = 3'd2;
    localparam logic [2:0] SRC_CYLL  = 3'd3;
    localparam logic [2:0] SRC_CYLH  = 3'd4;
    localparam logic [2:0] SRC_HEAD  = 3'd5;
    localparam logic [2:0] SRC_CMD   = 3'd6;
    localparam logic [2:0] SRC_WORD  = 3'd7;
endpackage
`default_nettype wire

>>> hdl/aps_divider.sv
// ----------------------------------------------------------------------------
// aps_divider
// Restoring divider, one quotient bit per cycle (28-bit by 8-bit).
// ----------------------------------------------------------------------------
`default_nettype none
module aps_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [27:0] i_num,
    input  wire logic [7:0]  i_den,
    output logic             o_done,
    output logic [27:0]      o_quot,
    output logic [7:0]       o_rem
);
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [27:0] r_q, n_q;
    logic [8:0]  r_r, n_r;
    logic [8:0]  w_trial;

    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        n_q = r_q; n_r = r_r;
        w_trial = {r_r[7:0], r_q[27]};
        if (i_start) begin
            n_busy = 1'b1; n_cnt = 5'd0; n_q = i_num; n_r = 9'd0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_r = w_trial - {1'b0, i_den};
                n_q = {r_q[26:0], 1'b1};
            end else begin
                n_r = w_trial;
                n_q = {r_q[26:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd27) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_cnt <= n_cnt; r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_r <= n_r;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[7:0];
endmodule
`default_nettype wire

>>> hdl/aps_datapath.sv
// ----------------------------------------------------------------------------
// aps_datapath
// Geometry conversion (two divides on a shared divider) and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ata_pio_chs_sector_sequencer_top_assert.svh"
module aps_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire aps_pkg::t_dp_cmd i_cmd,
    output aps_pkg::t_dp_status   o_sts,
    input  wire logic [27:0]      i_sector,
    input  wire logic [7:0]       i_count_val,
    input  wire logic             i_direction,
    input  wire logic [15:0]      i_word,
    input  wire logic [4:0]       i_heads,
    input  wire logic [7:0]       i_spt,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [2:0]            o_kind,
    output logic [31:0]           o_bus_address,
    output logic [15:0]           o_bus_data,
    output logic                  o_last
);
    import aps_pkg::*;

    logic        r_div_start, n_div_start;
    logic        r_stage, n_stage;     // 0: lin/spt, 1: quot/hpc
    logic        r_cdone, n_cdone;
    logic [7:0]  r_sec, n_sec;
    logic [27:0] r_cyl, n_cyl;
    logic [3:0]  r_head, n_head;
    logic [27:0] w_num;
    logic [7:0]  w_den;
    logic        w_ddone;
    logic [27:0] w_quot;
    logic [7:0]  w_rem;
    logic [7:0]  w_spt, w_hpc;

    assign w_spt = (i_spt == 8'd0) ? 8'd1 : i_spt;
    assign w_hpc = (i_heads == 5'd0) ? 8'd1 : {3'd0, i_heads};
    assign w_num = r_stage ? r_cyl : i_sector;
    assign w_den = r_stage ? w_hpc : w_spt;

    aps_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_quot(w_quot), .o_rem(w_rem)
    );

    // two-pass conversion sequence
    always_comb begin
        n_div_start = 1'b0; n_stage = r_stage; n_cdone = 1'b0;
        n_sec = r_sec; n_cyl = r_cyl; n_head = r_head;
        if (i_cmd.start_div) begin
            n_stage = 1'b0; n_div_start = 1'b1;
        end else if (w_ddone) begin
            if (!r_stage) begin
                n_sec = w_rem + 8'd1;
                n_cyl = w_quot;
                n_stage = 1'b1; n_div_start = 1'b1;
            end else begin
                n_head = w_rem[3:0];
                n_cyl = w_quot;
                n_cdone = 1'b1;
            end
        end
    end

    logic       r_valid;
    logic [2:0] r_kind;
    logic [31:0] r_addr;
    logic [15:0] r_data;
    logic       r_last;
    logic [15:0] w_src;

    always_comb begin
        case (i_cmd.src)
            SRC_ZERO:  w_src = 16'd0;
            SRC_COUNT: w_src = {8'd0, i_count_val};
            SRC_SECT:  w_src = {8'd0, r_sec};
            SRC_CYLL:  w_src = {8'd0, r_cyl[7:0]};
            SRC_CYLH:  w_src = r_cyl[23:8];
            SRC_HEAD:  w_src = {8'd0, DEV_SEL | {4'd0, r_head}};
            SRC_CMD:   w_src = {8'd0, i_direction ? CMD_WRITE : CMD_READ};
            SRC_WORD:  w_src = i_word;
            default:   w_src = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0; r_stage <= 1'b0; r_cdone <= 1'b0; r_valid <= 1'b0;
        end else begin
            r_div_start <= n_div_start; r_stage <= n_stage; r_cdone <= n_cdone;
            if (i_cmd.emit) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
        r_sec <= n_sec; r_cyl <= n_cyl; r_head <= n_head;
        // output register
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            r_addr <= (i_cmd.kind == K_BUS_WR || i_cmd.kind == K_BUS_RD)
                      ? (BUS_BASE + {27'd0, i_cmd.reg_idx, 2'b00}) : 32'd0;
            r_data <= w_src;
            r_last <= i_cmd.last;
        end
    end

    assign o_sts.div_done = r_cdone;
    assign o_sts.out_free = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_bus_address = r_addr;
    assign o_bus_data = r_data;
    assign o_last = r_last;

    `APS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_valid && !i_ready, !i_cmd.emit,
        "result overwritten while stalled")
    `APS_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, r_valid,
        "emitted result not shown")
    `APS_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_cmd.start_div, !r_div_start,
        "conversion restarted mid-flight")
endmodule
`default_nettype wire

>>> hdl/aps_controller.sv
// ----------------------------------------------------------------------------
// aps_controller
// Request, poll and word sequencing; emits one result per cycle at most.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ata_pio_chs_sector_sequencer_top_assert.svh"
module aps_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic [27:0]        i_linear_sector,
    input  wire logic [7:0]         i_sector_count,
    input  wire logic               i_is_write,
    input  wire logic [7:0]         i_status_byte,
    input  wire logic [15:0]        i_data_word,
    input  wire logic [7:0]         i_poll_limit,
    output aps_pkg::t_dp_cmd        o_cmd,
    input  wire aps_pkg::t_dp_status i_sts,
    output logic [27:0]             o_sector,
    output logic [7:0]              o_count_val,
    output logic                    o_direction,
    output logic [15:0]             o_word
);
    import aps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT_BUSY, S_WAIT_DATA, S_WORDS,
        S_EMIT_RD7, S_EMIT_TO, S_CONV, S_TF, S_EMIT_WORD, S_FINISH
    } t_state;

    // protocol phase
    typedef enum logic [1:0] {P_IDLE, P_BUSY, P_DATA, P_WORDS} t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic [7:0]  r_polls;
    logic [WIDX_W-1:0] r_widx;
    logic [27:0] r_sector;
    logic [7:0]  r_left;
    logic [7:0]  r_cntv;
    logic        r_dir;
    logic [15:0] r_word;
    logic [2:0]  r_tf;        // task-file write step
    logic        r_end;       // item produced no further result
    t_dp_cmd     w_cmd;
    logic        w_acc;
    logic        w_wait;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc = i_valid && o_ready;
    assign w_wait = (r_phase == P_BUSY) ? ((i_status_byte & ST_BUSY) != 8'd0)
                                        : ((i_status_byte & ST_DRQ) == 8'd0);

    always_comb begin
        w_cmd = '0;
        case (r_state)
            S_EMIT_RD7: begin
                w_cmd.emit = i_sts.out_free; w_cmd.kind = K_BUS_RD;
                w_cmd.reg_idx = r_phase == P_WORDS ? R_DATA : R_CMD;
                w_cmd.last = 1'b1;
            end
            S_EMIT_TO: begin
                // a write that times out on DRQ has nothing after the flag
                w_cmd.emit = i_sts.out_free; w_cmd.kind = K_TIMEOUT;
                w_cmd.last = (r_phase == P_WORDS) && r_dir;
            end
            S_TF: begin
                w_cmd.emit = i_sts.out_free; w_cmd.kind = K_BUS_WR;
                case (r_tf)
                    3'd0: begin w_cmd.reg_idx = R_COUNT; w_cmd.src = SRC_COUNT; end
                    3'd1: begin w_cmd.reg_idx = R_SECT;  w_cmd.src = SRC_SECT;  end
                    3'd2: begin w_cmd.reg_idx = R_CYLL;  w_cmd.src = SRC_CYLL;  end
                    3'd3: begin w_cmd.reg_idx = R_CYLH;  w_cmd.src = SRC_CYLH;  end
                    3'd4: begin w_cmd.reg_idx = R_HEAD;  w_cmd.src = SRC_HEAD;  end
                    default: begin w_cmd.reg_idx = R_CMD; w_cmd.src = SRC_CMD; end
                endcase
            end
            S_EMIT_WORD: begin
                w_cmd.emit = i_sts.out_free;
                w_cmd.kind = r_dir ? K_BUS_WR : K_WORD;
                w_cmd.reg_idx = R_DATA; w_cmd.src = SRC_WORD;
                w_cmd.last = r_end;
            end
            S_FINISH: begin
                w_cmd.emit = i_sts.out_free; w_cmd.kind = K_DONE; w_cmd.last = 1'b1;
            end
            default: w_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= P_IDLE; r_polls <= '0; r_widx <= '0;
            r_sector <= '0; r_left <= '0; r_cntv <= '0; r_dir <= 1'b0;
            r_tf <= '0; r_end <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_action == ACT_START) begin
                            r_sector <= i_linear_sector;
                            r_left <= (i_sector_count == 8'd0) ? 8'd1 : i_sector_count;
                            r_cntv <= (i_sector_count == 8'd0) ? 8'd0 : 8'd1;
                            r_dir <= i_is_write; r_widx <= '0;
                            r_phase <= P_BUSY; r_polls <= i_poll_limit;
                            r_state <= S_EMIT_RD7;
                        end else if (i_action == ACT_STATUS &&
                                     (r_phase == P_BUSY || r_phase == P_DATA)) begin
                            if (w_wait && r_polls != 8'd0) begin
                                r_polls <= r_polls - 8'd1;
                                r_state <= S_EMIT_RD7;
                            end else begin
                                if (r_phase == P_BUSY) begin
                                    r_state <= (r_polls == 8'd0) ? S_EMIT_TO : S_CONV;
                                end else begin
                                    r_phase <= P_WORDS; r_widx <= '0;
                                    if (r_polls == 8'd0) r_state <= S_EMIT_TO;
                                    else if (!r_dir) r_state <= S_EMIT_RD7;
                                end
                            end
                        end else if (i_action == ACT_DATA && r_phase == P_WORDS) begin
                            r_word <= i_data_word;
                            r_end <= (r_dir && r_widx != WIDX_W'(WORDS_PER_SECTOR - 1));
                            r_state <= S_EMIT_WORD;
                        end
                    end
                end
                S_EMIT_TO: if (i_sts.out_free) begin
                    if (r_phase == P_BUSY) r_state <= S_CONV;
                    else if (r_dir) r_state <= S_IDLE;
                    else r_state <= S_EMIT_RD7;
                end
                S_CONV: begin
                    // wait for the CHS result, launched on entry via start pulse
                    if (i_sts.div_done) begin
                        r_tf <= 3'd0; r_state <= S_TF;
                    end
                end
                S_TF: if (i_sts.out_free) begin
                    if (r_tf == 3'd5) begin
                        r_phase <= P_DATA; r_polls <= i_poll_limit;
                        r_state <= S_EMIT_RD7;
                    end else begin
                        r_tf <= r_tf + 3'd1;
                    end
                end
                S_EMIT_RD7: if (i_sts.out_free) r_state <= S_IDLE;
                S_EMIT_WORD: if (i_sts.out_free) begin
                    if (r_widx == WIDX_W'(WORDS_PER_SECTOR - 1)) begin
                        r_widx <= '0;
                        r_left <= r_left - 8'd1;
                        r_sector <= r_sector + 28'd1;
                        if (r_left != 8'd1) begin
                            r_phase <= P_BUSY; r_polls <= i_poll_limit;
                            r_state <= S_EMIT_RD7;
                        end else begin
                            r_phase <= P_IDLE; r_state <= S_FINISH;
                        end
                    end else begin
                        r_widx <= r_widx + 1'b1;
                        r_state <= r_dir ? S_IDLE : S_EMIT_RD7;
                    end
                end
                S_FINISH: if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // start pulse to the datapath when entering conversion
    logic r_conv_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_conv_q <= 1'b0;
        else r_conv_q <= (r_state == S_CONV);
    end

    always_comb begin
        o_cmd = w_cmd;
        o_cmd.start_div = (r_state == S_CONV) && !r_conv_q;
    end

    assign o_sector = r_sector;
    assign o_count_val = r_cntv;
    assign o_direction = r_dir;
    assign o_word = r_word;

    `APS_ASSERT_IMP(a_ready_no_emit, i_clk, i_rst_n, o_ready, !w_cmd.emit,
        "result emitted while accepting")
    `APS_ASSERT_IMP(a_widx_range, i_clk, i_rst_n, 1'b1,
        r_widx < WIDX_W'(WORDS_PER_SECTOR), "word index out of range")
    `APS_ASSERT_IMP(a_tf_range, i_clk, i_rst_n, r_state == S_TF, r_tf <= 3'd5,
        "task-file step out of range")
endmodule
`default_nettype wire

>>> hdl/ata_pio_chs_sector_sequencer_top.sv
// ----------------------------------------------------------------------------
// ata_pio_chs_sector_sequencer_top
// Host-side ATA PIO sequencer: start, status and data beats in, bus ops out.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. The poll that ends the BSY wait runs the
// sector-to-CHS conversion on a shared bit-serial divider (two divides) and
// then emits the six task-file writes and a status read, one result per cycle
// while the output is not stalled. Results leave through a one-beat output
// register, so an output stall holds the sequence.
`default_nettype none
module ata_pio_chs_sector_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [27:0] i_linear_sector,
    input  wire logic [7:0]  i_sector_count,
    input  wire logic        i_is_write,
    input  wire logic [7:0]  i_status_byte,
    input  wire logic [15:0] i_data_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_bus_address,
    output logic [15:0]      o_bus_data,
    output logic             o_last
);
    import aps_pkg::*;

    logic [4:0] r_heads;
    logic [7:0] r_spt;
    logic [7:0] r_poll;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads <= 5'd1; r_spt <= 8'd1; r_poll <= POLL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADS: r_heads <= i_cfg_data[4:0];
                CFG_SPT:   r_spt <= i_cfg_data;
                CFG_POLL:  r_poll <= i_cfg_data;
                default:   r_poll <= r_poll;
            endcase
        end
    end

    t_dp_cmd     w_cmd;
    t_dp_status  w_sts;
    logic [27:0] w_sector;
    logic [7:0]  w_cntv;
    logic        w_dir;
    logic [15:0] w_word;

    aps_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_linear_sector(i_linear_sector),
        .i_sector_count(i_sector_count), .i_is_write(i_is_write),
        .i_status_byte(i_status_byte), .i_data_word(i_data_word),
        .i_poll_limit(r_poll), .o_cmd(w_cmd), .i_sts(w_sts),
        .o_sector(w_sector), .o_count_val(w_cntv), .o_direction(w_dir), .o_word(w_word)
    );

    aps_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_sector(w_sector), .i_count_val(w_cntv), .i_direction(w_dir), .i_word(w_word),
        .i_heads(r_heads), .i_spt(r_spt), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_bus_address(o_bus_address), .o_bus_data(o_bus_data),
        .o_last(o_last)
    );
endmodule
`default_nettype wire
